### sv/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher unit.
package rc4_pkg;

    // Widths fixed by the register map and the byte datapath.
    localparam int KEY_W        = 64;
    localparam int NUM_KEY_REGS = 4;
    localparam int KLEN_W       = 6;
    localparam int SKIP_W       = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int PERM_DEPTH   = 256;

    // Last index of the permutation table.
    localparam logic [7:0] PERM_LAST = 8'hFF;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY0 = 3'd0,
        REG_KEY1 = 3'd1,
        REG_KEY2 = 3'd2,
        REG_KEY3 = 3'd3,
        REG_KLEN = 3'd4,
        REG_SKIP = 3'd5
    } cfg_reg_t;

    // Access request from the sequencer to the permutation memory.
    typedef struct packed {
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic [7:0] raddr;
    } sbox_req_t;

    // Status and result from the sequencer to the top level.
    typedef struct packed {
        logic       idle;
        logic       done;
        logic [7:0] out_byte;
        logic       last_out;
        logic       key_error;
    } seq_res_t;

endpackage

### sv/rc4_sbox.sv
// Permutation memory: one write port and one registered read port, write-first.
module rc4_sbox import rc4_pkg::*;
(
    input  logic       clk,
    input  sbox_req_t  req,
    output logic [7:0] rdata
);

    logic [7:0] mem [PERM_DEPTH];
    logic [7:0] rdata_reg;

    // A read of the address written in the same cycle returns the new data.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.we && (req.waddr == req.raddr))
        begin
            rdata_reg <= req.wdata;
        end
        else
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/rc4_seq.sv
// Sequencer for key schedule, keystream drop and keystream generation.
module rc4_seq import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [7:0]                     data_byte,
    input  logic                           last_byte,
    input  logic [NUM_KEY_REGS*KEY_W-1:0]  key_vec,
    input  logic [KLEN_W-1:0]              key_length,
    input  logic [SKIP_W-1:0]              skip_count,
    input  logic                           take,
    input  logic [7:0]                     rdata,
    output sbox_req_t                      req,
    output seq_res_t                       res
);

    localparam int KPOS_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [KLEN_W-1:0] KLEN_MAX = KLEN_W'(MAX_KEY_BYTES);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_KS_RD,
        S_KS_MIX,
        S_KS_SWAP_A,
        S_KS_SWAP_B,
        S_PR_RD,
        S_PR_J,
        S_PR_SWAP,
        S_PR_OUT,
        S_PR_DONE,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [7:0]          n_reg;
    logic [7:0]          i_reg;
    logic [7:0]          j_reg;
    logic [KPOS_W-1:0]   kpos_reg;
    logic [KLEN_W-1:0]   klen_reg;
    logic [SKIP_W-1:0]   skip_reg;
    logic                fresh_reg;
    logic [7:0]          sa_reg;
    logic [7:0]          sb_reg;
    logic [7:0]          data_reg;
    logic                last_reg;
    logic [7:0]          res_byte_reg;
    logic                res_err_reg;

    logic [7:0]          key_byte;
    logic [7:0]          ks_j;
    logic [7:0]          pr_j;
    logic [KLEN_W-1:0]   klen_eff;
    logic                kpos_wrap;

    // Byte adders for the index updates.
    assign key_byte  = key_vec[{kpos_reg, 3'b000} +: 8];
    assign ks_j      = j_reg + rdata + key_byte;
    assign pr_j      = j_reg + rdata;
    assign klen_eff  = (key_length > KLEN_MAX) ? KLEN_MAX : key_length;
    assign kpos_wrap = (KLEN_W'(kpos_reg) + KLEN_W'(1)) >= klen_reg;

    // Memory access for each step.
    always_comb
    begin
        req       = '0;
        req.raddr = i_reg + 8'd1;
        unique case (state_reg)
            S_INIT:
            begin
                req.we    = 1'b1;
                req.waddr = n_reg;
                req.wdata = n_reg;
            end
            S_KS_RD:
            begin
                req.raddr = n_reg;
            end
            S_KS_MIX:
            begin
                req.raddr = ks_j;
            end
            S_KS_SWAP_A:
            begin
                req.we    = 1'b1;
                req.waddr = n_reg;
                req.wdata = rdata;
            end
            S_KS_SWAP_B:
            begin
                req.we    = 1'b1;
                req.waddr = j_reg;
                req.wdata = sa_reg;
                req.raddr = n_reg + 8'd1;
            end
            S_PR_J:
            begin
                req.raddr = pr_j;
            end
            S_PR_SWAP:
            begin
                req.we    = 1'b1;
                req.waddr = i_reg;
                req.wdata = rdata;
            end
            S_PR_OUT:
            begin
                req.we    = 1'b1;
                req.waddr = j_reg;
                req.wdata = sa_reg;
                req.raddr = sa_reg + sb_reg;
            end
            default:
            begin
            end
        endcase
    end

    // State and registered results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            n_reg        <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            kpos_reg     <= '0;
            klen_reg     <= '0;
            skip_reg     <= '0;
            fresh_reg    <= 1'b1;
            sa_reg       <= '0;
            sb_reg       <= '0;
            data_reg     <= '0;
            last_reg     <= 1'b0;
            res_byte_reg <= '0;
            res_err_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        data_reg <= data_byte;
                        last_reg <= last_byte;
                        if (key_length == '0)
                        begin
                            // No key: pass the byte through and flag it.
                            res_byte_reg <= data_byte;
                            res_err_reg  <= 1'b1;
                            fresh_reg    <= fresh_reg | last_byte;
                            state_reg    <= S_DONE;
                        end
                        else if (fresh_reg)
                        begin
                            klen_reg  <= klen_eff;
                            skip_reg  <= skip_count;
                            n_reg     <= '0;
                            state_reg <= S_INIT;
                        end
                        else
                        begin
                            // The read of entry i+1 was issued in this cycle.
                            i_reg     <= i_reg + 8'd1;
                            state_reg <= S_PR_J;
                        end
                    end
                end
                S_INIT:
                begin
                    n_reg <= n_reg + 8'd1;
                    if (n_reg == PERM_LAST)
                    begin
                        j_reg     <= '0;
                        kpos_reg  <= '0;
                        state_reg <= S_KS_RD;
                    end
                end
                S_KS_RD:
                begin
                    state_reg <= S_KS_MIX;
                end
                S_KS_MIX:
                begin
                    sa_reg    <= rdata;
                    j_reg     <= ks_j;
                    state_reg <= S_KS_SWAP_A;
                end
                S_KS_SWAP_A:
                begin
                    state_reg <= S_KS_SWAP_B;
                end
                S_KS_SWAP_B:
                begin
                    kpos_reg <= kpos_wrap ? '0 : kpos_reg + KPOS_W'(1);
                    n_reg    <= n_reg + 8'd1;
                    if (n_reg == PERM_LAST)
                    begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        state_reg <= S_PR_RD;
                    end
                    else
                    begin
                        state_reg <= S_KS_MIX;
                    end
                end
                S_PR_RD:
                begin
                    i_reg     <= i_reg + 8'd1;
                    state_reg <= S_PR_J;
                end
                S_PR_J:
                begin
                    sa_reg    <= rdata;
                    j_reg     <= pr_j;
                    state_reg <= S_PR_SWAP;
                end
                S_PR_SWAP:
                begin
                    sb_reg    <= rdata;
                    state_reg <= S_PR_OUT;
                end
                S_PR_OUT:
                begin
                    state_reg <= S_PR_DONE;
                end
                S_PR_DONE:
                begin
                    if (skip_reg != '0)
                    begin
                        // Dropped keystream byte.
                        skip_reg  <= skip_reg - SKIP_W'(1);
                        state_reg <= S_PR_RD;
                    end
                    else
                    begin
                        res_byte_reg <= data_reg ^ rdata;
                        res_err_reg  <= 1'b0;
                        fresh_reg    <= last_reg;
                        state_reg    <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res.idle      = (state_reg == S_IDLE);
    assign res.done      = (state_reg == S_DONE);
    assign res.out_byte  = res_byte_reg;
    assign res.last_out  = last_reg;
    assign res.key_error = res_err_reg;

endmodule

### sv/rc4_stream_cipher_unit.sv
// RC4 stream cipher unit with keystream drop: top level, registers and output stage.
//
// One byte is transformed per input transfer, one at a time. The time a byte in
// the middle of a message takes is set by the permutation memory with its one
// registered read port: three dependent reads and two writes per keystream
// byte. The first byte of a message also fills the 256-entry table, runs the
// key schedule and drops skip_count keystream bytes before the next input
// transfer is possible. With key_length zero a byte passes through with
// key_error set. The finished result sits in an output register, so the next
// byte is taken while it waits on out_stall.
module rc4_stream_cipher_unit import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output logic                 last_out,
    output logic                 key_error
);

    logic [KEY_W-1:0]               key_reg [NUM_KEY_REGS];
    logic [KLEN_W-1:0]              key_length_reg;
    logic [SKIP_W-1:0]              skip_count_reg;
    logic [NUM_KEY_REGS*KEY_W-1:0]  key_vec;

    logic                           out_valid_reg;
    logic [7:0]                     out_byte_reg;
    logic                           last_out_reg;
    logic                           key_error_reg;

    logic                           start;
    logic                           take;
    logic [7:0]                     rdata;
    sbox_req_t                      req;
    seq_res_t                       res;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KEY_REGS; k++)
            begin
                key_reg[k] <= '0;
            end
            key_length_reg <= '0;
            skip_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY0: key_reg[0]     <= cfg_data;
                REG_KEY1: key_reg[1]     <= cfg_data;
                REG_KEY2: key_reg[2]     <= cfg_data;
                REG_KEY3: key_reg[3]     <= cfg_data;
                REG_KLEN: key_length_reg <= cfg_data[KLEN_W-1:0];
                REG_SKIP: skip_count_reg <= cfg_data[SKIP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign key_vec = {key_reg[3], key_reg[2], key_reg[1], key_reg[0]};

    // Input transfers are taken only while the sequencer is idle.
    assign in_stall = !res.idle;
    assign start    = in_valid && !in_stall;

    // The result moves to the output register when that register is free.
    assign take = res.done && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            last_out_reg  <= 1'b0;
            key_error_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
            out_byte_reg  <= res.out_byte;
            last_out_reg  <= res.last_out;
            key_error_reg <= res.key_error;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_out  = last_out_reg;
    assign key_error = key_error_reg;

    rc4_seq #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .key_vec    (key_vec),
        .key_length (key_length_reg),
        .skip_count (skip_count_reg),
        .take       (take),
        .rdata      (rdata),
        .req        (req),
        .res        (res)
    );

    rc4_sbox u_sbox (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

endmodule
